// ===== rtl/rwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

    localparam int KSIZE      = 3;
    localparam int TAPS       = KSIZE * KSIZE;
    localparam int LINE_DEPTH = 1024;
    localparam int ADDR_W     = 10;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int COEF_W     = 12;
    localparam int ROW_W      = 13;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_KROW0  = 3'd0;
    localparam logic [2:0] REG_KROW1  = 3'd1;
    localparam logic [2:0] REG_KROW2  = 3'd2;
    localparam logic [2:0] REG_KROW3  = 3'd3;
    localparam logic [2:0] REG_KROW4  = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;

    localparam logic [0:0] OP_PIXEL = 1'b0;

    // one window column, index 0 = top row
    typedef logic [KSIZE-1:0][PIX_W-1:0] t_col;
    // window, index 0 = leftmost column
    typedef t_col [KSIZE-1:0] t_win;

    typedef struct packed {
        logic [11:0] orow;
        logic [9:0]  ocol;
        logic        last;
    } t_job_meta;

    // pixel times Q1.10 coefficient, round half to even, clamp to 0..255
    function automatic logic [7:0] scale_prod(input logic [7:0] p, input logic [11:0] c);
        logic signed [20:0] prod;
        logic [18:0]        u;
        logic [8:0]         q;
        logic [9:0]         rem;
        logic [9:0]         qr;
        logic               up;
        logic [7:0]         res;
        prod = $signed({1'b0, p}) * $signed(c);
        u    = prod[18:0];
        q    = u[18:10];
        rem  = u[9:0];
        up   = (rem > 10'd512) || ((rem == 10'd512) && q[0]);
        qr   = {1'b0, q} + {9'd0, up};
        if (prod <= 21'sd0) begin
            res = 8'd0;
        end else if (qr > 10'd255) begin
            res = 8'd255;
        end else begin
            res = qr[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_window_convolution_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 3x3 zero-padded convolution of an RGB pixel stream, one kernel per all channels.
// Input stream: s_axis_tdata carries one pixel, s_axis_tuser says pixel (0) or
// drain tick (1). Send frames in raster order, then image_width drain ticks for
// the row below the image. Output stream: one transfer per filtered pixel with
// its row and column; tlast marks the last pixel of the frame.
// Throughput: one item per cycle while the receiver accepts; the last column of each
// row from row 1 on produces two results when the width exceeds one, so that item
// holds the input while the second result is made. Pipeline: the line memory is read
// at the transfer edge, then window build, product lane, sum lane registers.
// Line memory: 1024 x 48 bits, holding the two previous rows per column.
// APB port programs kernel rows (5 x 12-bit Q1.10 per row, rows 0..2 used),
// width and height; writing width or height restarts the frame. Program only
// while the stream is idle.
// Reset clears position, window, kernel rows and all valid flags and sets width and
// height to 1024; the line memory is not cleared, as out-of-image rows are masked.
// When the receiver stalls, the whole pipeline holds and input tready drops.
module rgb_window_convolution_unit
    import rwc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // chan0_in, chan1_in, chan2_in
    input  wire logic [0:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // chan0_out, chan1_out, chan2_out,
                                             // out_row, out_col, zero pad
    output logic             m_axis_tlast,   // last_in_frame
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // configuration
    logic [59:0]      r_krow [5];
    logic [10:0]      r_width;
    logic [ROW_W-1:0] r_height;
    logic [2:0]       cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_krow[i] <= '0;
            end
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KROW0:  r_krow[0] <= pwdata[59:0];
                REG_KROW1:  r_krow[1] <= pwdata[59:0];
                REG_KROW2:  r_krow[2] <= pwdata[59:0];
                REG_KROW3:  r_krow[3] <= pwdata[59:0];
                REG_KROW4:  r_krow[4] <= pwdata[59:0];
                REG_WIDTH:  r_width   <= pwdata[10:0];
                REG_HEIGHT: r_height  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KROW0:  prdata = {4'd0, r_krow[0]};
            REG_KROW1:  prdata = {4'd0, r_krow[1]};
            REG_KROW2:  prdata = {4'd0, r_krow[2]};
            REG_KROW3:  prdata = {4'd0, r_krow[3]};
            REG_KROW4:  prdata = {4'd0, r_krow[4]};
            REG_WIDTH:  prdata = {53'd0, r_width};
            REG_HEIGHT: prdata = {51'd0, r_height};
            default:    prdata = 64'd0;
        endcase
    end

    // effective geometry
    logic [10:0]      eff_w;
    logic [ROW_W-1:0] eff_h;

    always_comb begin
        eff_w = r_width;
        if (r_width == 11'd0) eff_w = 11'd1;
        if (r_width > 11'd1024) eff_w = 11'd1024;
        eff_h = r_height;
        if (r_height == 13'd0) eff_h = 13'd1;
        if (r_height > 13'd4096) eff_h = 13'd4096;
    end

    // pipeline control: everything advances when the output register frees up
    logic r_out_valid;
    logic adv;
    logic stay;
    logic acc;

    logic                r_s1_valid;
    logic                r_s1_pix;
    logic [PIX_W-1:0]    r_s1_data;
    logic [ROW_W-1:0]    r_s1_r;
    logic [ADDR_W-1:0]   r_s1_c;
    logic                r_s1_ge1;
    logic                r_s1_ge2;
    logic                r_s1_inimg;
    logic                r_s1_has1;
    logic                r_s1_has2;
    logic                r_s1_last;
    logic                r_phase;

    assign adv           = !r_out_valid || m_axis_tready;
    assign stay          = r_s1_valid && r_s1_has1 && r_s1_has2 && !r_phase;
    assign s_axis_tready = adv && !stay;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // raster position
    logic [ROW_W-1:0]  r_in_row;
    logic [ADDR_W-1:0] r_in_col;
    logic [ROW_W-1:0]  cur_r;
    logic [ADDR_W-1:0] cur_c;
    logic              cur_inimg;
    logic              ignore;
    logic              c_is_last;
    logic [10:0]       c_next;
    logic [ROW_W-1:0]  r_next;
    logic [ROW_W-1:0]  n_in_row;
    logic [ADDR_W-1:0] n_in_col;

    always_comb begin
        cur_r = r_in_row;
        cur_c = r_in_col;
        if ((r_in_row > eff_h) || ({1'b0, r_in_col} >= eff_w)) begin
            cur_r = '0;
            cur_c = '0;
        end
        cur_inimg = cur_r < eff_h;
        ignore    = cur_inimg && (s_axis_tuser[0] != OP_PIXEL);
        c_is_last = ({1'b0, cur_c} == (eff_w - 11'd1));
        c_next    = {1'b0, cur_c} + 11'd1;
        r_next    = cur_r + 13'd1;
        n_in_row  = cur_r;
        n_in_col  = c_next[ADDR_W-1:0];
        if (c_next >= eff_w) begin
            n_in_col = '0;
            n_in_row = (r_next > eff_h) ? 13'd0 : r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT))) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (acc && !ignore) begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
        end
    end

    // stage 1: item with line memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv && !stay) begin
            r_s1_valid <= acc && !ignore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix   <= cur_inimg;
            r_s1_data  <= s_axis_tdata;
            r_s1_r     <= cur_r;
            r_s1_c     <= cur_c;
            r_s1_ge1   <= cur_r >= 13'd1;
            r_s1_ge2   <= cur_r >= 13'd2;
            r_s1_inimg <= cur_inimg;
            r_s1_has1  <= (cur_r >= 13'd1) && (cur_c >= 10'd1);
            r_s1_has2  <= (cur_r >= 13'd1) && c_is_last;
            r_s1_last  <= (cur_r == eff_h) && c_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (adv) begin
            r_phase <= stay;
        end
    end

    logic                 consume;
    logic                 mem_we;
    logic [2*PIX_W-1:0]   mem_q;
    logic [2*PIX_W-1:0]   mem_wd;

    assign consume = adv && r_s1_valid && !r_phase;
    assign mem_we  = consume && r_s1_pix;
    // upper half: row above, lower half: two rows above
    assign mem_wd  = {r_s1_data, mem_q[2*PIX_W-1:PIX_W]};

    rwc_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_re    (acc),
        .i_raddr (cur_c),
        .o_rdata (mem_q),
        .i_we    (mem_we),
        .i_waddr (r_s1_c),
        .i_wdata (mem_wd)
    );

    // window: shift in the new column, masking rows outside the image
    t_win r_win;
    t_win nw;
    t_col ncol;
    t_win src;
    t_win jwin;
    logic shift1;
    t_job_meta jmeta;

    always_comb begin
        ncol[0] = r_s1_ge2   ? mem_q[PIX_W-1:0]         : '0;
        ncol[1] = r_s1_ge1   ? mem_q[2*PIX_W-1:PIX_W]   : '0;
        ncol[2] = r_s1_inimg ? r_s1_data                : '0;
        if (r_s1_c == '0) begin
            nw[0] = '0;
            nw[1] = '0;
        end else begin
            nw[0] = r_win[1];
            nw[1] = r_win[2];
        end
        nw[2] = ncol;
        src    = r_phase ? r_win : nw;
        shift1 = r_phase || !r_s1_has1;
        if (shift1) begin
            jwin[0] = src[1];
            jwin[1] = src[2];
            jwin[2] = '0;
        end else begin
            jwin = src;
        end
        jmeta.orow = r_s1_r[11:0] - 12'd1;
        jmeta.ocol = shift1 ? r_s1_c : (r_s1_c - 10'd1);
        jmeta.last = shift1 && r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (consume) begin
            r_win <= nw;
        end
    end

    // stage 2: job register
    logic      r_job_valid;
    t_win      r_job_win;
    t_job_meta r_job_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (adv) begin
            r_job_valid <= r_s1_valid && (r_phase || r_s1_has1 || r_s1_has2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_job_win  <= jwin;
            r_job_meta <= jmeta;
        end
    end

    // coefficients per tap, tap k = row * KSIZE + column
    logic [TAPS-1:0][COEF_W-1:0] coef;
    logic [TAPS-1:0][CH_W-1:0]   lane_pix [3];

    always_comb begin
        for (int dr = 0; dr < KSIZE; dr++) begin
            for (int dc = 0; dc < KSIZE; dc++) begin
                coef[dr*KSIZE+dc] = r_krow[dr][dc*COEF_W +: COEF_W];
                for (int ch = 0; ch < 3; ch++) begin
                    lane_pix[ch][dr*KSIZE+dc] = r_job_win[dc][dr][ch*CH_W +: CH_W];
                end
            end
        end
    end

    // stages 3 and 4: one lane per channel
    logic [CH_W-1:0] lane_sum [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rwc_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_pix  (lane_pix[g]),
            .i_coef (coef),
            .o_sum  (lane_sum[g])
        );
    end

    // merge: track valid and position alongside the lanes
    logic      r_a_valid;
    t_job_meta r_a_meta;
    t_job_meta r_out_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= r_job_valid;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_meta   <= r_job_meta;
            r_out_meta <= r_a_meta;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_meta.ocol, r_out_meta.orow,
                            lane_sum[2], lane_sum[1], lane_sum[0]};
    assign m_axis_tlast  = r_out_meta.last;

endmodule

`default_nettype wire

// ===== rtl/rwc_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rwc_line_mem
    import rwc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_re,
    input  wire logic [ADDR_W-1:0]    i_raddr,
    output logic      [2*PIX_W-1:0]   o_rdata,
    input  wire logic                 i_we,
    input  wire logic [ADDR_W-1:0]    i_waddr,
    input  wire logic [2*PIX_W-1:0]   i_wdata
);

    logic [2*PIX_W-1:0] r_mem [LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // forward a same-address write so a one-pixel row sees fresh data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                o_rdata <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_raddr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rwc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rwc_lane
    import rwc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [TAPS-1:0][CH_W-1:0]     i_pix,
    input  wire logic [TAPS-1:0][COEF_W-1:0]   i_coef,
    output logic      [CH_W-1:0]               o_sum
);

    logic [CH_W-1:0] r_sc [TAPS];
    logic [11:0]     tot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < TAPS; k++) begin
                r_sc[k] <= scale_prod(i_pix[k], i_coef[k]);
            end
        end
    end

    // all terms are nonnegative, so clamping the total equals running saturation
    always_comb begin
        tot = 12'd0;
        for (int k = 0; k < TAPS; k++) begin
            tot = tot + {4'd0, r_sc[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum <= (tot > 12'd255) ? 8'd255 : tot[7:0];
        end
    end

endmodule

`default_nettype wire
